[sv/hpx_pkg.sv]
`default_nettype none
package hpx_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 4;
	localparam int ORDER_W    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_RES_ORDER = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_NESTED    = 4'd1;

	// geometry carried alongside the square root chain
	typedef struct packed {
		logic [31:0] azim;
		logic [34:0] np;
		logic [34:0] nm;
		logic        equ;
		logic        s_pos;
		logic        s_neg;
	} hpx_side_t;

	typedef struct packed {
		logic [ORDER_W-1:0] order;
		logic               nested;
	} hpx_cfg_t;

endpackage
`default_nettype wire

[sv/healpix_angle_to_pixel.sv]
`default_nettype none
// sky direction to healpix pixel index, ring or nested ordering
// input channel: a beat is taken at a clock edge with start high and busy low;
// cos_zenith is q1.30 signed, azimuth_turns is a fraction of a full turn
// busy stays low: the pipeline takes one direction every cycle
// result: pixel_index is shown for one cycle with pixel_valid high; the input
// beat passes one front stage, 32 square root stages (one result bit each,
// the polar sqrt(3(1-|z|)) term) and five stages of products and pixel
// assembly on its way to the output
// throughput is one item per clock
// configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// index 0 is resolution_order, index 1 is nested_ordering, others are ignored;
// write only while no item is in flight
// reset clears both registers (order 0, ring ordering) and empties the pipeline
// the receiver cannot stall, so no backpressure exists
module healpix_angle_to_pixel #(
	parameter int MAX_ORDER = 13
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [31:0]            cos_zenith,
	input  wire logic [31:0]                   azimuth_turns,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hpx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hpx_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                               pixel_valid,
	output logic [29:0]                        pixel_index
);

	localparam int STEPS = 32;

	logic [3:0] resolution_order_q;
	logic       nested_ordering_q;
	hpx_pkg::hpx_cfg_t cfg;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_order_q <= 4'd0;
			nested_ordering_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hpx_pkg::CFG_IDX_RES_ORDER: resolution_order_q <= cfg_data[3:0];
				hpx_pkg::CFG_IDX_NESTED:    nested_ordering_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.order  = (resolution_order_q > 4'(MAX_ORDER)) ? 4'(MAX_ORDER)
	                                                        : resolution_order_q;
	assign cfg.nested = nested_ordering_q;

	// front stage: saturate z, band test, edge line numerators, sqrt operand
	logic signed [31:0] s_sat;
	logic [31:0]        za_w;
	logic [30:0]        za;
	logic [32:0]        three_za;
	logic signed [35:0] s_ext;
	logic signed [35:0] s3;
	logic signed [35:0] a4;
	logic signed [35:0] np_w;
	logic signed [35:0] nm_w;
	logic [30:0]        d_w;
	logic [32:0]        d3;
	hpx_pkg::hpx_side_t side_w;

	always_comb begin
		if (cos_zenith > 32'sh4000_0000) s_sat = 32'sh4000_0000;
		else if (cos_zenith < -32'sh4000_0000) s_sat = -32'sh4000_0000;
		else s_sat = cos_zenith;
	end

	assign za_w     = s_sat[31] ? 32'(-s_sat) : 32'(s_sat);
	assign za       = za_w[30:0];
	assign three_za = {1'b0, za, 1'b0} + {2'b00, za};
	assign s_ext    = 36'(s_sat);
	assign s3       = s_ext + (s_ext <<< 1);
	assign a4       = $signed({2'b00, azimuth_turns, 2'b00});
	assign np_w     = 36'sh8000_0000 + a4 - s3;
	assign nm_w     = 36'sh8000_0000 + a4 + s3;
	assign d_w      = 31'h4000_0000 - za;
	assign d3       = {1'b0, d_w, 1'b0} + {2'b00, d_w};

	assign side_w.azim  = azimuth_turns;
	assign side_w.np    = np_w[34:0];
	assign side_w.nm    = nm_w[34:0];
	assign side_w.equ   = three_za <= 33'h0_8000_0000;
	assign side_w.s_pos = ~s_sat[31] & (s_sat != 32'sd0);
	assign side_w.s_neg = s_sat[31];

	logic               valid_s1;
	logic [63:0]        v_s1;
	hpx_pkg::hpx_side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= {d3[31:0], 32'b0};
		side_s1 <= side_w;
	end

	// square root chain, one result bit per stage
	logic               ch_valid [STEPS+1];
	logic [63:0]        ch_v     [STEPS+1];
	logic [63:0]        ch_r     [STEPS+1];
	hpx_pkg::hpx_side_t ch_side  [STEPS+1];

	assign ch_valid[0] = valid_s1;
	assign ch_v[0]     = v_s1;
	assign ch_r[0]     = 64'd0;
	assign ch_side[0]  = side_s1;

	for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
		hpx_sqrt_step #(.STEP(k)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (ch_valid[k]),
			.in_v     (ch_v[k]),
			.in_r     (ch_r[k]),
			.in_side  (ch_side[k]),
			.out_valid(ch_valid[k+1]),
			.out_v    (ch_v[k+1]),
			.out_r    (ch_r[k+1]),
			.out_side (ch_side[k+1])
		);
	end

	logic unused_v;
	assign unused_v = ^{ch_v[STEPS], ch_r[STEPS][63:32]};

	hpx_pixel #(.MAX_ORDER(MAX_ORDER)) u_pixel (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ch_valid[STEPS] | (unused_v & 1'b0)),
		.sq       (ch_r[STEPS][31:0]),
		.in_side  (ch_side[STEPS]),
		.cfg      (cfg),
		.out_valid(pixel_valid),
		.pixel    (pixel_index)
	);

endmodule
`default_nettype wire

[sv/hpx_sqrt_step.sv]
`default_nettype none
module hpx_sqrt_step #(
	parameter int STEP = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [63:0]       in_v,
	input  wire logic [63:0]       in_r,
	input  wire hpx_pkg::hpx_side_t in_side,
	output logic                   out_valid,
	output logic [63:0]            out_v,
	output logic [63:0]            out_r,
	output hpx_pkg::hpx_side_t     out_side
);

	localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

	logic              valid_s1;
	logic [63:0]       v_s1;
	logic [63:0]       r_s1;
	hpx_pkg::hpx_side_t side_s1;
	logic [63:0]       trial;
	logic [63:0]       v_nx;
	logic [63:0]       r_nx;

	always_comb begin
		trial = in_r + BIT;
		if (in_v >= trial) begin
			v_nx = in_v - trial;
			r_nx = (in_r >> 1) + BIT;
		end else begin
			v_nx = in_v;
			r_nx = in_r >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= v_nx;
		r_s1    <= r_nx;
		side_s1 <= in_side;
	end

	assign out_valid = valid_s1;
	assign out_v     = v_s1;
	assign out_r     = r_s1;
	assign out_side  = side_s1;

endmodule
`default_nettype wire

[sv/hpx_pixel.sv]
`default_nettype none
module hpx_pixel #(
	parameter int MAX_ORDER = 13
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [31:0]        sq,
	input  wire hpx_pkg::hpx_side_t in_side,
	input  wire hpx_pkg::hpx_cfg_t  cfg,
	output logic                    out_valid,
	output logic [29:0]             pixel
);

	localparam int JW = MAX_ORDER + 3;
	localparam int PW = 32 + JW + 1;
	localparam int QW = 2 * (JW + 1);
	localparam logic [JW-1:0] NS_M1 = JW'((1 << MAX_ORDER) - 1);

	logic [3:0] sh;
	logic [5:0] sh_eq;
	logic [5:0] sh_pol;
	assign sh     = cfg.nested ? 4'(MAX_ORDER) : cfg.order;
	assign sh_eq  = 6'd32 - {2'b00, sh};
	assign sh_pol = 6'd61 - {2'b00, sh};

	// stage 1: first polar product and equatorial edge lines
	logic              valid_s1;
	logic [31:0]       sq_s1;
	logic [61:0]       prod_f_s1;
	logic [JW-1:0]     jp_eq_s1;
	logic [JW-1:0]     jm_eq_s1;
	hpx_pkg::hpx_side_t side_s1;
	logic [34:0]       np_sh;
	logic [34:0]       nm_sh;
	assign np_sh = in_side.np >> sh_eq;
	assign nm_sh = in_side.nm >> sh_eq;

	// stage 2
	logic              valid_s2;
	logic [61:0]       prod_g_s2;
	logic [JW-1:0]     jp_pol_s2;
	logic [JW-1:0]     jp_eq_s2;
	logic [JW-1:0]     jm_eq_s2;
	hpx_pkg::hpx_side_t side_s2;
	logic [30:0]       g_w;
	logic [61:0]       pf_sh;
	assign g_w   = 31'h4000_0000 - {1'b0, side_s1.azim[29:0]};
	assign pf_sh = prod_f_s1 >> sh_pol;

	// stage 3
	logic              valid_s3;
	logic [JW-1:0]     jp_s3;
	logic [JW-1:0]     jm_s3;
	hpx_pkg::hpx_side_t side_s3;
	logic [61:0]       pg_sh;
	logic [JW-1:0]     jp_sel;
	logic [JW-1:0]     jm_sel;
	assign pg_sh = prod_g_s2 >> sh_pol;

	always_comb begin
		if (side_s2.equ) begin
			jp_sel = jp_eq_s2;
			jm_sel = jm_eq_s2;
		end else begin
			jp_sel = jp_pol_s2;
			jm_sel = pg_sh[JW-1:0];
			if (cfg.nested) begin
				if (jp_sel > NS_M1) jp_sel = NS_M1;
				if (jm_sel > NS_M1) jm_sel = NS_M1;
			end
		end
	end

	// stage 4: ring equatorial and nested pixels, ring polar products
	logic              valid_s4;
	logic [31:0]       pix_s4;
	logic [PW-1:0]     prod_a_s4;
	logic [QW-1:0]     ir_sq_s4;
	logic [JW:0]       ir_s4;
	logic              ring_pol_s4;
	logic              s_pos_s4;

	logic [31:0]            n_w;
	logic [31:0]            ncap_w;
	logic [31:0]            ir_e;
	logic [31:0]            ip_num;
	logic [31:0]            ip_e;
	logic [31:0]            pix_e;
	logic [JW:0]            ir_p;
	logic [2:0]             ifp;
	logic [2:0]             ifm;
	logic [3:0]             face;
	logic [MAX_ORDER-1:0]   ix;
	logic [MAX_ORDER-1:0]   iy;
	logic [2*MAX_ORDER-1:0] il;
	logic [5:0]             il_sh;
	logic [5:0]             face_sh;
	logic [31:0]            pix_n;

	assign n_w    = 32'(1) << cfg.order;
	assign ncap_w = (32'(1) << ({cfg.order, 1'b0} + 5'd1)) - (32'(1) << (cfg.order + 4'd1));
	assign ir_e   = n_w + 32'd1 + 32'(jp_s3) - 32'(jm_s3);
	assign ip_num = 32'(jp_s3) + 32'(jm_s3) + 32'd1 + {31'b0, ~ir_e[0]} - n_w;
	assign ip_e   = (ip_num >> 1) & ((n_w << 2) - 32'd1);
	assign pix_e  = ncap_w + ((ir_e - 32'd1) << (cfg.order + 4'd2)) + ip_e;
	assign ir_p   = (JW+1)'(jp_s3) + (JW+1)'(jm_s3) + (JW+1)'(1);

	always_comb begin
		ifp = 3'(jp_s3 >> MAX_ORDER);
		ifm = 3'(jm_s3 >> MAX_ORDER);
		if (side_s3.equ) begin
			if (ifp == ifm) face = (ifp == 3'd4) ? 4'd4 : {1'b0, ifp} + 4'd4;
			else if (ifp < ifm) face = {1'b0, ifp};
			else face = {1'b0, ifm} + 4'd8;
			ix = jm_s3[MAX_ORDER-1:0];
			iy = ~jp_s3[MAX_ORDER-1:0];
		end else if (!side_s3.s_neg) begin
			face = {2'b00, side_s3.azim[31:30]};
			ix = ~jm_s3[MAX_ORDER-1:0];
			iy = ~jp_s3[MAX_ORDER-1:0];
		end else begin
			face = {2'b00, side_s3.azim[31:30]} + 4'd8;
			ix = jp_s3[MAX_ORDER-1:0];
			iy = jm_s3[MAX_ORDER-1:0];
		end
		for (int b = 0; b < MAX_ORDER; b++) begin
			il[2*b]   = ix[b];
			il[2*b+1] = iy[b];
		end
	end

	assign il_sh   = 6'(2 * MAX_ORDER) - {1'b0, cfg.order, 1'b0};
	assign face_sh = {1'b0, cfg.order, 1'b0};
	assign pix_n   = 32'(il >> il_sh) + (32'(face) << face_sh);

	// stage 5: ring polar pixel and output register
	logic        valid_s5;
	logic [29:0] pix_s5;
	logic [31:0] npix_w;
	logic [31:0] ip_p;
	logic [31:0] irsq_w;
	logic [31:0] ir_w;
	logic [31:0] pix_p;
	logic [31:0] pix_fin;

	assign npix_w = 32'd3 << ({cfg.order, 1'b0} + 5'd2);
	assign ip_p   = 32'(prod_a_s4 >> 30);
	assign irsq_w = 32'(ir_sq_s4);
	assign ir_w   = 32'(ir_s4);
	assign pix_p  = s_pos_s4 ? (((irsq_w - ir_w) << 1) + ip_p)
	                         : (npix_w - ((irsq_w + ir_w) << 1) + ip_p);
	assign pix_fin = ring_pol_s4 ? pix_p : pix_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1     <= sq;
		prod_f_s1 <= 62'(sq) * 62'(in_side.azim[29:0]);
		jp_eq_s1  <= np_sh[JW-1:0];
		jm_eq_s1  <= nm_sh[JW-1:0];
		side_s1   <= in_side;

		prod_g_s2 <= 62'(sq_s1) * 62'(g_w);
		jp_pol_s2 <= pf_sh[JW-1:0];
		jp_eq_s2  <= jp_eq_s1;
		jm_eq_s2  <= jm_eq_s1;
		side_s2   <= side_s1;

		jp_s3   <= jp_sel;
		jm_s3   <= jm_sel;
		side_s3 <= side_s2;

		pix_s4      <= cfg.nested ? pix_n : pix_e;
		prod_a_s4   <= PW'(side_s3.azim) * PW'(ir_p);
		ir_sq_s4    <= QW'(ir_p) * QW'(ir_p);
		ir_s4       <= ir_p;
		ring_pol_s4 <= ~cfg.nested & ~side_s3.equ;
		s_pos_s4    <= side_s3.s_pos;

		pix_s5 <= pix_fin[29:0];
	end

	assign out_valid = valid_s5;
	assign pixel     = pix_s5;

endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;

	localparam int LATENCY   = 38;
	localparam int MAX_ORD   = 13;
	localparam int CYCLE_CAP = 400000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	logic signed [31:0]             cos_zenith = '0;
	logic [31:0]                    azimuth_turns = '0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [hpx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [hpx_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           pixel_valid;
	logic [29:0]                    pixel_index;

	logic [29:0] pixel_queue[$];
	logic [3:0]  order_reg = 4'd0;
	logic        nested_reg = 1'b0;
	int          errors = 0;
	int          sent = 0;
	int          settings = 0;
	int          cycles = 0;

	healpix_angle_to_pixel #(.MAX_ORDER(MAX_ORD)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cos_zenith(cos_zenith), .azimuth_turns(azimuth_turns),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel_valid(pixel_valid), .pixel_index(pixel_index)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("healpix_angle_to_pixel: mismatch");
			$finish;
		end
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned weave(longint unsigned x, longint unsigned y);
		longint unsigned p;
		p = 0;
		for (int b = 0; b < MAX_ORD; b++) begin
			p |= ((x >> b) & 64'd1) << (2 * b);
			p |= ((y >> b) & 64'd1) << (2 * b + 1);
		end
		return p;
	endfunction

	function automatic logic [29:0] pixel_of(logic signed [31:0] cz, logic [31:0] az,
			logic [3:0] ord_r, logic nest);
		longint          s, jp, jm, n, ir, ksh, ip, nps, nms;
		longint unsigned a, nside, ncap, npix, pix, za, npu, nmu, d, sq, f, g;
		longint unsigned jpu, jmu, iru, ipu, face, ix, iy, nsmax;
		int              order;
		s = cz;
		a = az;
		if (s > (64'sd1 << 30))
			s = 64'sd1 << 30;
		if (s < -(64'sd1 << 30))
			s = -(64'sd1 << 30);
		order = (ord_r > MAX_ORD) ? MAX_ORD : int'(ord_r);
		nside = 64'd1 << order;
		ncap = 2 * (nside * nside - nside);
		npix = 12 * nside * nside;
		za = (s < 0) ? longint'(-s) : longint'(s);
		nsmax = 64'd1 << MAX_ORD;
		if (3 * za <= (64'd1 << 31)) begin
			nps = (64'sd1 << 31) + longint'(a << 2) - 3 * s;
			nms = (64'sd1 << 31) + longint'(a << 2) + 3 * s;
			npu = nps;
			nmu = nms;
			if (!nest) begin
				jp = longint'((npu << order) >> 32);
				jm = longint'((nmu << order) >> 32);
				n = longint'(nside);
				ir = n + 1 + jp - jm;
				ksh = 1 - (ir & 1);
				ip = (jp + jm - n + ksh + 1) / 2;
				ip = ip % (4 * n);
				if (ip < 0)
					ip += 4 * n;
				pix = ncap + longint'(ir - 1) * 4 * nside + longint'(ip);
			end else begin
				jpu = (npu << MAX_ORD) >> 32;
				jmu = (nmu << MAX_ORD) >> 32;
				if ((jpu >> MAX_ORD) == (jmu >> MAX_ORD))
					face = ((jpu >> MAX_ORD) == 4) ? 4 : (jpu >> MAX_ORD) + 4;
				else if ((jpu >> MAX_ORD) < (jmu >> MAX_ORD))
					face = jpu >> MAX_ORD;
				else
					face = (jmu >> MAX_ORD) + 8;
				ix = jmu & (nsmax - 1);
				iy = nsmax - (jpu & (nsmax - 1)) - 1;
				pix = (weave(ix, iy) >> (2 * (MAX_ORD - order))) + (face << (2 * order));
			end
		end else begin
			d = (64'd1 << 30) - za;
			sq = isqrt((3 * d) << 32);
			f = a & 64'h3FFF_FFFF;
			g = (64'd1 << 30) - f;
			if (!nest) begin
				jpu = (sq * f) >> (61 - order);
				jmu = (sq * g) >> (61 - order);
				iru = jpu + jmu + 1;
				ipu = ((a * iru) >> 30) % (4 * iru);
				if (s > 0)
					pix = 2 * iru * (iru - 1) + ipu;
				else
					pix = npix - 2 * iru * (iru + 1) + ipu;
			end else begin
				jpu = (sq * f) >> (61 - MAX_ORD);
				jmu = (sq * g) >> (61 - MAX_ORD);
				// clamp edge indices at the cap rim
				if (jpu >= nsmax)
					jpu = nsmax - 1;
				if (jmu >= nsmax)
					jmu = nsmax - 1;
				if (s >= 0) begin
					face = a >> 30;
					ix = nsmax - jmu - 1;
					iy = nsmax - jpu - 1;
				end else begin
					face = (a >> 30) + 8;
					ix = jpu;
					iy = jmu;
				end
				pix = (weave(ix, iy) >> (2 * (MAX_ORD - order))) + (face << (2 * order));
			end
		end
		return pix[29:0];
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && pixel_valid) begin
			if (pixel_queue.size() == 0) begin
				$display("%0t: unexpected pixel beat, expected none, actual %0d",
					$time, pixel_index);
				errors++;
			end else begin
				if (pixel_index !== pixel_queue[0]) begin
					$display("%0t: pixel_index expected %0d actual %0d",
						$time, pixel_queue[0], pixel_index);
					errors++;
				end
				void'(pixel_queue.pop_front());
			end
		end
	end

	// leaves start high so back-to-back beats need no extra assignment
	task automatic send_dir(logic signed [31:0] cz, logic [31:0] az);
		start <= 1'b1;
		cos_zenith <= cz;
		azimuth_turns <= az;
		do @(posedge clk); while (busy);
		pixel_queue.push_back(pixel_of(cz, az, order_reg, nested_reg));
		sent++;
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pixel_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [hpx_pkg::CFG_IDX_W-1:0] idx,
			logic [hpx_pkg::CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == hpx_pkg::CFG_IDX_RES_ORDER)
			order_reg = val;
		else if (idx == hpx_pkg::CFG_IDX_NESTED)
			nested_reg = val[0];
	endtask

	task automatic set_mode(logic [3:0] ord, logic nest);
		write_reg(hpx_pkg::CFG_IDX_RES_ORDER, ord);
		write_reg(hpx_pkg::CFG_IDX_NESTED, {3'b0, nest});
		settings++;
	endtask

	function automatic logic signed [31:0] rand_z();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 10)
			return $urandom;
		else if (k < 20)
			return 32'sd715827882 + $signed($urandom_range(0, 8)) - 32'sd4;
		else if (k < 30)
			return (32'sd1 << 30) - $signed($urandom_range(0, 2000));
		else if (k < 40)
			return -(32'sd1 << 30) + $signed($urandom_range(0, 2000));
		else
			return $signed($urandom_range(0, 32'h8000_0000)) - (32'sd1 << 30);
	endfunction

	task automatic test_edges();
		logic signed [31:0] zs[12];
		logic [31:0]        as[4];
		zs = '{32'sh4000_0000, -32'sh4000_0000, 32'sd0, 32'sd715827882, 32'sd715827883,
			-32'sd715827882, -32'sd715827883, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh4000_0001, 32'sh3FFF_FFFF, -32'sh3FFF_FFFF};
		as = '{32'h0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF};
		for (int i = 0; i < 12; i++)
			send_dir(zs[i], as[i % 4]);
		send_dir(32'sd0, 32'h8000_0000);
	endtask

	task automatic test_random(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && count > 0) begin
				send_dir(rand_z(), $urandom);
				burst--;
				count--;
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end
	endtask

	task automatic test_unknown_index();
		for (int i = 2; i < 16; i++)
			write_reg(i[hpx_pkg::CFG_IDX_W-1:0], hpx_pkg::CFG_DATA_W'($urandom));
		test_random(20);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_random(10);
		set_mode(4'd0, 1'b0);
		test_edges();
		set_mode(4'd13, 1'b1);
		test_edges();
		set_mode(4'd13, 1'b0);
		test_random(120);
		set_mode(4'd0, 1'b1);
		test_random(120);
		set_mode(4'd15, 1'b1);
		test_random(80);
		set_mode(4'd14, 1'b0);
		test_random(80);
		set_mode(4'($urandom_range(1, 12)), 1'b0);
		test_random(100);
		set_mode(4'($urandom_range(1, 12)), 1'b1);
		test_unknown_index();
		test_random(100);
		for (int k = 0; k < 4; k++) begin
			set_mode(4'($urandom), 1'($urandom));
			test_random(75);
		end
		drain();
		$display("%0d directions sent over %0d register settings", sent, settings);
		$display("orders 0, 13, 14, 15 and random in ring and nested, band and caps");
		if (errors == 0)
			$display("healpix_angle_to_pixel: match");
		else
			$display("healpix_angle_to_pixel: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
